@@ rtl/prmt_pkg.sv @@
package prmt_pkg;

    // operation codes carried on cmd; code 3 is unused and does nothing
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_SEARCH = 2'd2
    } cmd_e;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_e;

    // table update strobes from the execute stage
    typedef struct packed {
        logic clear;
        logic insert;
    } tbl_ctrl_t;

endpackage

@@ rtl/port_range_match_table.sv @@
// Port range match table.
// Item channel (item_valid / item_ready): cmd with range_first, range_last
// and port. cmd clear empties the table, insert appends first..last, search
// looks up port against every stored range at once.
// Result channel (result_valid / result_ready): one beat per item with hit,
// port_count and status. An insert with last below first gives status empty,
// one into a full table gives status full; neither changes the table.
// An accepted item passes the input register, then the result register,
// before its result beat is offered. Throughput: one item per cycle while
// the receiver keeps taking results, set by the single compare stage; an
// insert is visible to the very next item.
// Reset empties the table; stored bounds are not cleared, they are simply
// never compared until rewritten.
// When the receiver stalls the result register holds, the input register
// keeps one further item, and item_ready drops only when both are occupied.
module port_range_match_table #(
    parameter int MAX_RANGES = 16,
    parameter int PORT_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  logic [1:0]           cmd,
    input  logic [PORT_BITS-1:0] range_first,
    input  logic [PORT_BITS-1:0] range_last,
    input  logic [PORT_BITS-1:0] port,
    output logic                 result_valid,
    input  logic                 result_ready,
    output logic                 hit,
    output logic [PORT_BITS:0]   port_count,
    output logic [1:0]           status
);

    // input register
    logic                 s1_vld_reg;
    logic                 s1_vld_next;
    logic [1:0]           s1_cmd_reg;
    logic [PORT_BITS-1:0] s1_first_reg;
    logic [PORT_BITS-1:0] s1_last_reg;
    logic [PORT_BITS-1:0] s1_port_reg;

    // result register
    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [PORT_BITS:0]   count_reg;
    logic [PORT_BITS:0]   count_next;
    prmt_pkg::status_e    status_reg;
    prmt_pkg::status_e    status_next;

    logic                 advance;
    logic                 take;
    logic                 tbl_hit;
    logic                 tbl_full;
    prmt_pkg::tbl_ctrl_t  tbl_ctrl;

    // result stage free, or emptying this cycle
    assign advance    = !out_vld_reg || result_ready;
    assign take       = s1_vld_reg && advance;
    assign item_ready = !s1_vld_reg || advance;

    prmt_table #(
        .MAX_RANGES (MAX_RANGES),
        .PORT_BITS  (PORT_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (tbl_ctrl),
        .wr_low    (s1_first_reg),
        .wr_high   (s1_last_reg),
        .look_port (s1_port_reg),
        .look_hit  (tbl_hit),
        .full      (tbl_full)
    );

    // execute: decide result and table update for the item in s1
    always_comb
    begin
        tbl_ctrl    = '0;
        hit_next    = 1'b0;
        count_next  = '0;
        status_next = prmt_pkg::ST_OK;
        case (prmt_pkg::cmd_e'(s1_cmd_reg))
            prmt_pkg::CMD_CLEAR:
            begin
                tbl_ctrl.clear = take;
            end
            prmt_pkg::CMD_INSERT:
            begin
                if (s1_last_reg < s1_first_reg)
                begin
                    status_next = prmt_pkg::ST_EMPTY;
                end
                else if (tbl_full)
                begin
                    status_next = prmt_pkg::ST_FULL;
                end
                else
                begin
                    tbl_ctrl.insert = take;
                    count_next = {1'b0, s1_last_reg} - {1'b0, s1_first_reg}
                                 + (PORT_BITS + 1)'(1);
                end
            end
            prmt_pkg::CMD_SEARCH:
            begin
                hit_next = tbl_hit;
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        s1_vld_next = s1_vld_reg;
        if (item_valid && item_ready)
        begin
            s1_vld_next = 1'b1;
        end
        else if (take)
        begin
            s1_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (take)
        begin
            out_vld_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            s1_cmd_reg   <= cmd;
            s1_first_reg <= range_first;
            s1_last_reg  <= range_last;
            s1_port_reg  <= port;
        end
        if (take)
        begin
            hit_reg    <= hit_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign hit          = hit_reg;
    assign port_count   = count_reg;
    assign status       = status_reg;

    // a rejected insert reports no span and no hit
    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && status_reg != prmt_pkg::ST_OK) |-> (count_reg == '0 && !hit_reg))
        else $error("rejected insert carries count or hit");

    // a hit only comes from a search, which reports no span
    a_hit_search: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && hit_reg) |-> (count_reg == '0 && status_reg == prmt_pkg::ST_OK))
        else $error("hit with count or status set");

    // back-pressure only when both registers hold a beat and the sink stalls
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> (s1_vld_reg && out_vld_reg && !result_ready))
        else $error("item_ready low without a full stall");

    // a beat moved on from s1 always shows up as a result next cycle
    a_take_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_vld_reg)
        else $error("taken item lost before result register");

endmodule

@@ rtl/prmt_table.sv @@
module prmt_table #(
    parameter int MAX_RANGES = 16,
    parameter int PORT_BITS  = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  prmt_pkg::tbl_ctrl_t    ctrl,
    input  logic [PORT_BITS-1:0]   wr_low,
    input  logic [PORT_BITS-1:0]   wr_high,
    input  logic [PORT_BITS-1:0]   look_port,
    output logic                   look_hit,
    output logic                   full
);

    localparam int COUNT_W = $clog2(MAX_RANGES + 1);
    localparam int IDX_W   = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;

    logic [PORT_BITS-1:0] low_reg  [MAX_RANGES];
    logic [PORT_BITS-1:0] high_reg [MAX_RANGES];
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [MAX_RANGES-1:0] lane_hit;
    logic [IDX_W-1:0]     wr_idx;

    assign wr_idx = count_reg[IDX_W-1:0];
    assign full   = (count_reg >= COUNT_W'(MAX_RANGES));

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.insert)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // entry storage, no reset: only entries below the count are compared
    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            low_reg[wr_idx]  <= wr_low;
            high_reg[wr_idx] <= wr_high;
        end
    end

    // one comparator pair per entry
    always_comb
    begin
        for (int k = 0; k < MAX_RANGES; k++)
        begin
            lane_hit[k] = (COUNT_W'(k) < count_reg) &&
                          (low_reg[k] <= look_port) && (look_port <= high_reg[k]);
        end
    end

    assign look_hit = |lane_hit;

endmodule

@@ dv/tb_port_range_match_table.sv @@
`timescale 1ns / 1ps

module tb_port_range_match_table;

    localparam int TBL_DEPTH   = 16;
    localparam int PORT_W      = 16;
    localparam int ITEM_TARGET = 1200;

    // cmd code 3 is left unused by the block: no table change, all-zero result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // receiver hold-off: starts once this many beats are in, lasts this long
    localparam int unsigned HOLD_AT     = 300;
    localparam int unsigned HOLD_CYCLES = 200;

    // window (in accepted beats) in which neither side idles at random
    localparam int unsigned CLEAN_FROM = 500;
    localparam int unsigned CLEAN_TO   = 800;

    // one beat on the item channel, plus a flag telling the driver to let
    // every outstanding result come back before offering it
    typedef struct packed {
        logic [1:0]        op;
        logic [PORT_W-1:0] first;
        logic [PORT_W-1:0] last;
        logic [PORT_W-1:0] port;
        logic              drain_first;
    } port_req_t;

    typedef struct packed {
        logic              hit;
        logic [PORT_W:0]   span;
        logic [1:0]        status;
    } range_result_t;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_ready;
    logic [1:0]        cmd = prmt_pkg::CMD_CLEAR;
    logic [PORT_W-1:0] range_first = '0;
    logic [PORT_W-1:0] range_last = '0;
    logic [PORT_W-1:0] port = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    logic              hit;
    logic [PORT_W:0]   port_count;
    logic [1:0]        status;

    port_range_match_table #(
        .MAX_RANGES(TBL_DEPTH),
        .PORT_BITS (PORT_W)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .cmd         (cmd),
        .range_first (range_first),
        .range_last  (range_last),
        .port        (port),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .hit         (hit),
        .port_count  (port_count),
        .status      (status)
    );

    // -------------------------------------------------------------------
    // Shared bookkeeping
    // -------------------------------------------------------------------
    port_req_t     pending_items[$];     // filled up front, drained by the driver
    range_result_t expected_results[$];  // one per accepted beat, oldest first
    port_req_t     live_beat;            // beat currently on the item port

    int unsigned   beats_taken   = 0;    // item beats accepted
    int unsigned   results_seen  = 0;    // result beats accepted
    int unsigned   total_queued  = 0;
    int unsigned   error_count   = 0;
    int unsigned   hold_left     = 0;
    bit            hold_fired    = 1'b0;

    // recent valid ranges, used to aim searches at range edges
    logic [PORT_W-1:0] known_lo[$];
    logic [PORT_W-1:0] known_hi[$];

    // -------------------------------------------------------------------
    // Table predictor: own copy of the bounds and the fill level
    // -------------------------------------------------------------------
    logic [PORT_W-1:0] lo_bound [TBL_DEPTH];
    logic [PORT_W-1:0] hi_bound [TBL_DEPTH];
    int unsigned       ranges_held = 0;

    function automatic range_result_t apply_to_table(port_req_t req);
        range_result_t r;
        r = '0;
        case (req.op)
            prmt_pkg::CMD_CLEAR:  ranges_held = 0;
            prmt_pkg::CMD_INSERT:
                // an empty range is checked before a full table
                if (req.last < req.first)
                    r.status = prmt_pkg::ST_EMPTY;
                else if (ranges_held >= TBL_DEPTH)
                    r.status = prmt_pkg::ST_FULL;
                else
                begin
                    lo_bound[ranges_held] = req.first;
                    hi_bound[ranges_held] = req.last;
                    ranges_held++;
                    r.span = {1'b0, req.last} - {1'b0, req.first} + 1'b1;
                end
            prmt_pkg::CMD_SEARCH:
                // union of all live entries; overlaps and duplicates are fine
                for (int k = 0; k < TBL_DEPTH; k++)
                    if (k < ranges_held && lo_bound[k] <= req.port && req.port <= hi_bound[k])
                        r.hit = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit stretch_clean();
        return beats_taken >= CLEAN_FROM && beats_taken < CLEAN_TO;
    endfunction

    task automatic flag_error(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // -------------------------------------------------------------------
    // Stimulus helpers
    // -------------------------------------------------------------------
    task automatic queue_beat(input logic [1:0] op, input logic [PORT_W-1:0] f,
                              input logic [PORT_W-1:0] l, input logic [PORT_W-1:0] p,
                              input bit drain = 1'b0);
        port_req_t b;
        b.op          = op;
        b.first       = f;
        b.last        = l;
        b.port        = p;
        b.drain_first = drain;
        pending_items.push_back(b);
        total_queued++;
    endtask

    // mix of shapes: arbitrary pairs (often inverted), wildcard, single
    // ports, ranges hugging either end, deliberately inverted, ordinary spans
    task automatic pick_range(output logic [PORT_W-1:0] lo, output logic [PORT_W-1:0] hi);
        int unsigned base;
        int unsigned width;
        case ($urandom_range(9))
            0:
            begin
                lo = PORT_W'($urandom);
                hi = PORT_W'($urandom);
            end
            1:
            begin
                lo = '0;
                hi = '1;
            end
            2:
            begin
                lo = PORT_W'($urandom);
                hi = lo;
            end
            3:
            begin
                lo = {PORT_W{1'b1}} - PORT_W'($urandom_range(40));
                hi = '1;
            end
            4:
            begin
                lo = '0;
                hi = PORT_W'($urandom_range(40));
            end
            5:
            begin
                hi = PORT_W'($urandom);
                lo = hi + PORT_W'(1) + PORT_W'($urandom_range(50));
            end
            default:
            begin
                base  = $urandom_range(65535);
                width = $urandom_range(3000);
                lo    = PORT_W'(base);
                hi    = (base + width > 65535) ? 16'hFFFF : PORT_W'(base + width);
            end
        endcase
    endtask

    // search ports: mostly one off / on a known range edge, else an extreme or anywhere
    function automatic logic [PORT_W-1:0] probe_port();
        int unsigned idx;
        logic [PORT_W-1:0] edge_pt;
        if (known_lo.size() == 0 || $urandom_range(4) == 0)
            return PORT_W'($urandom);
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? {PORT_W{1'b1}} : {PORT_W{1'b0}};
        idx     = $urandom_range(known_lo.size() - 1);
        edge_pt = $urandom_range(1) ? known_lo[idx] : known_hi[idx];
        return PORT_W'(edge_pt + $urandom_range(2) - 1);
    endfunction

    // -------------------------------------------------------------------
    // Clock and reset
    // -------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // release on a falling edge, clear of the block's sampling edge
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // -------------------------------------------------------------------
    // Driver: item side. Predicts on the accepting edge, then picks what
    // (if anything) goes on the port next. Valid is only dropped or
    // reloaded once the current beat has gone in.
    // -------------------------------------------------------------------
    always @(posedge clk)
    begin : tx_side
        bit          taken;
        bit          go;
        int unsigned taken_total;
        if (rst_n)
        begin
            taken = item_valid && item_ready;
            if (taken)
            begin
                expected_results.push_back(apply_to_table(live_beat));
                beats_taken <= beats_taken + 1;
            end
            taken_total = beats_taken + taken;
            if (!item_valid || taken)
            begin
                go = pending_items.size() != 0 &&
                     (stretch_clean() || $urandom_range(99) >= 24);
                // sender pause: wait for every outstanding result
                if (go && pending_items[0].drain_first && taken_total != results_seen)
                    go = 1'b0;
                if (go)
                begin
                    live_beat    = pending_items.pop_front();
                    item_valid  <= 1'b1;
                    cmd         <= live_beat.op;
                    range_first <= live_beat.first;
                    range_last  <= live_beat.last;
                    port        <= live_beat.port;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, once, so the block backs up and drops item_ready
    always @(posedge clk)
    begin
        if (!hold_fired && beats_taken >= HOLD_AT)
        begin
            hold_fired <= 1'b1;
            hold_left  <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // -------------------------------------------------------------------
    // Monitor: result side. Every accepted beat is checked field by field
    // against the oldest prediction.
    // -------------------------------------------------------------------
    always @(posedge clk)
    begin : rx_side
        range_result_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    flag_error($sformatf(
                        "result beat with nothing expected: hit %0b count %0d status %0d",
                        hit, port_count, status));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (hit !== want.hit)
                        flag_error($sformatf("result %0d hit: got %b want %b",
                                             results_seen, hit, want.hit));
                    if (port_count !== want.span)
                        flag_error($sformatf("result %0d port_count: got %0d want %0d",
                                             results_seen, port_count, want.span));
                    if (status !== want.status)
                        flag_error($sformatf("result %0d status: got %0d want %0d",
                                             results_seen, status, want.status));
                end
            end
            result_ready <= (hold_left == 0) && (stretch_clean() || $urandom_range(99) >= 24);
        end
    end

    // -------------------------------------------------------------------
    // Stimulus and end of run
    // -------------------------------------------------------------------
    initial
    begin
        logic [PORT_W-1:0] lo;
        logic [PORT_W-1:0] hi;
        bit                drain;
        bit                first_seq;

        // directed: empty table, field extremes, every command
        queue_beat(prmt_pkg::CMD_SEARCH, '0, '0, '0);
        queue_beat(prmt_pkg::CMD_SEARCH, '1, '1, '1);
        queue_beat(prmt_pkg::CMD_INSERT, '1, '0, '0);          // last below first
        queue_beat(prmt_pkg::CMD_INSERT, '0, '1, '1);          // wildcard, spans all ports
        queue_beat(prmt_pkg::CMD_SEARCH, '0, '0, 16'h8000);
        queue_beat(prmt_pkg::CMD_CLEAR, '1, '1, '1);
        queue_beat(prmt_pkg::CMD_SEARCH, '0, '0, 16'h8000);    // miss after clear
        queue_beat(prmt_pkg::CMD_INSERT, 16'd100, 16'd200, '0);
        queue_beat(prmt_pkg::CMD_SEARCH, '0, '0, 16'd99);
        queue_beat(prmt_pkg::CMD_SEARCH, '0, '0, 16'd100);
        queue_beat(prmt_pkg::CMD_SEARCH, '0, '0, 16'd200);
        queue_beat(prmt_pkg::CMD_SEARCH, '0, '0, 16'd201);
        queue_beat(CMD_UNUSED, '1, '1, 16'd150);               // no effect, zero result
        queue_beat(prmt_pkg::CMD_INSERT, '1, '1, '0);          // single port at the top
        queue_beat(prmt_pkg::CMD_SEARCH, '0, '0, '1);
        // fill to the brim, with one range overlapping an earlier one among them
        for (int k = 0; k < TBL_DEPTH - 2; k++)
            queue_beat(prmt_pkg::CMD_INSERT, PORT_W'(k * 7),
                       (k == 5) ? 16'd200 : PORT_W'(k * 7), '0);
        queue_beat(prmt_pkg::CMD_INSERT, 16'd5, 16'd6, '0);    // table full
        queue_beat(prmt_pkg::CMD_INSERT, 16'd9, 16'd8, '0);    // empty wins over full
        queue_beat(prmt_pkg::CMD_SEARCH, '0, '0, 16'd14);

        // random: mostly clear-fill-probe sequences, some raw noise
        first_seq = 1'b1;
        while (total_queued < ITEM_TARGET)
        begin
            if ($urandom_range(9) == 0)
            begin
                repeat ($urandom_range(1, 6))
                    queue_beat(2'($urandom_range(3)), PORT_W'($urandom),
                               PORT_W'($urandom), PORT_W'($urandom));
            end
            else
            begin
                drain = first_seq || $urandom_range(11) == 0;
                first_seq = 1'b0;
                if ($urandom_range(3) != 0)
                begin
                    queue_beat(prmt_pkg::CMD_CLEAR, PORT_W'($urandom), PORT_W'($urandom),
                               PORT_W'($urandom), drain);
                    drain = 1'b0;
                    known_lo.delete();
                    known_hi.delete();
                end
                repeat ($urandom_range(1, 18))
                begin
                    pick_range(lo, hi);
                    queue_beat(prmt_pkg::CMD_INSERT, lo, hi, PORT_W'($urandom), drain);
                    drain = 1'b0;
                    if (lo <= hi)
                    begin
                        known_lo.push_back(lo);
                        known_hi.push_back(hi);
                        if (known_lo.size() > 48)
                        begin
                            void'(known_lo.pop_front());
                            void'(known_hi.pop_front());
                        end
                    end
                    repeat ($urandom_range(2))
                        queue_beat(prmt_pkg::CMD_SEARCH, PORT_W'($urandom),
                                   PORT_W'($urandom), probe_port());
                end
                repeat ($urandom_range(2, 12))
                    queue_beat(prmt_pkg::CMD_SEARCH, PORT_W'($urandom),
                               PORT_W'($urandom), probe_port());
            end
        end

        // everything offered, accepted and answered, then a short tail
        do
            @(posedge clk);
        while (pending_items.size() != 0 || item_valid || results_seen != beats_taken);
        repeat (8) @(posedge clk);
        if (expected_results.size() != 0)
            flag_error($sformatf("%0d expected results never arrived", expected_results.size()));
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ port_range_match_table.f @@
rtl/prmt_pkg.sv
rtl/prmt_table.sv
rtl/port_range_match_table.sv
dv/tb_port_range_match_table.sv
